### rtl/gpn_pkg.sv
// Shared types, constants and helpers of the grid partition neighbor generator.
`default_nettype none

package gpn_pkg;

  localparam int NumAxes  = 3;
  localparam int AxisX    = 0;
  localparam int AxisY    = 1;
  localparam int AxisZ    = 2;

  localparam int PartW    = 5;   // partition count and internal coordinate
  localparam int CoordW   = 4;   // coordinate as reported
  localparam int RankW    = 12;
  localparam int SizeW    = 16;
  localparam int EndW     = 17;
  localparam int TermW    = 10;  // y + py*z partial rank
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegGlobalSizeX = 3'd0,
    RegGlobalSizeY = 3'd1,
    RegGlobalSizeZ = 3'd2,
    RegPartsX      = 3'd3,
    RegPartsY      = 3'd4,
    RegPartsZ      = 3'd5
  } cfg_reg_e;

  // configuration view shared by front and back
  typedef struct packed {
    logic [NumAxes-1:0][PartW-1:0] parts;  // effective (clamped) counts
    logic [NumAxes-1:0][SizeW-1:0] lsize;  // cells per partition
    logic                          busy;   // local sizes being recomputed
  } cfg_t;

  // decoded rank handed from front to back
  typedef struct packed {
    logic                          err;
    logic [NumAxes-1:0][PartW-1:0] coord;
  } mid_t;

  // one result item
  typedef struct packed {
    logic                          rank_error;
    logic [NumAxes-1:0][CoordW-1:0] part;
    logic [RankW-1:0]              rank;
    logic [NumAxes-1:0][SizeW-1:0] first;
    logic [NumAxes-1:0][EndW-1:0]  lastcell;
    logic                          last;
  } res_t;

  // a count of zero acts as one, a count above the limit as the limit
  function automatic logic [PartW-1:0] clamp_parts(input logic [PartW-1:0] p,
                                                   input logic [PartW-1:0] lim);
    logic [PartW-1:0] r;
    r = p;
    if (r == '0) begin
      r = PartW'(1);
    end
    if (r > lim) begin
      r = lim;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/gpn_div.sv
// Restoring divider by a small count, one quotient bit per cycle.
`default_nettype none

module gpn_div #(
  parameter int DW = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DW-1:0]             dividend_i,
  input  logic [gpn_pkg::PartW-1:0] divisor_i,
  output logic                      done_o,
  output logic [DW-1:0]             quot_o,
  output logic [gpn_pkg::PartW-1:0] rem_o
);

  localparam int PW   = gpn_pkg::PartW;
  localparam int CntW = $clog2(DW + 1);

  logic [DW-1:0]   q_q, q_d;
  logic [PW-1:0]   r_q, r_d;
  logic [PW-1:0]   dvs_q, dvs_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [PW:0]     trial;

  // one shift-subtract step per cycle; start restarts at any time
  always_comb begin
    q_d    = q_q;
    r_d    = r_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {r_q, q_q[DW-1]};
    if (start_i) begin
      q_d    = dividend_i;
      r_d    = '0;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        r_d = PW'(trial - {1'b0, dvs_q});
        q_d = {q_q[DW-2:0], 1'b1};
      end else begin
        r_d = trial[PW-1:0];
        q_d = {q_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    r_q   <= r_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule

`default_nettype wire

### rtl/gpn_fifo.sv
// Small register queue with full and empty flags.
`default_nettype none

module gpn_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/gpn_cfg.sv
// Configuration registers and per-axis local size derivation.
`default_nettype none

module gpn_cfg #(
  parameter int MAX_PARTS_PER_AXIS = 16,
  parameter int COORD_WIDTH        = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [gpn_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gpn_pkg::CfgDataW-1:0] cfg_data_i,
  output gpn_pkg::cfg_t                cfg_o
);

  localparam int PW       = gpn_pkg::PartW;
  localparam int SW       = gpn_pkg::SizeW;
  localparam int NA       = gpn_pkg::NumAxes;
  localparam int LastAxis = NA - 1;
  localparam logic [PW-1:0] PartsLim =
      (MAX_PARTS_PER_AXIS >= (1 << PW) - 1) ? PW'((1 << PW) - 1) : PW'(MAX_PARTS_PER_AXIS);
  localparam logic [SW-1:0] GsMask =
      (COORD_WIDTH >= SW) ? {SW{1'b1}} : SW'((64'd1 << COORD_WIDTH) - 64'd1);

  logic [SW-1:0] gsize_q [NA];
  logic [PW-1:0] parts_q [NA];
  logic [SW-1:0] lsize_q [NA];
  logic [PW-1:0] eff     [NA];
  logic          kick_q;
  logic          busy_q;
  logic [1:0]    axis_q;
  logic [1:0]    nxt_axis;
  logic          div_start, div_done;
  logic [SW-1:0] div_quot;

  // register writes; any write to a size or count register restarts derivation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NA; a++) begin
        gsize_q[a] <= SW'(1);
        parts_q[a] <= PW'(1);
      end
      kick_q <= 1'b0;
    end else begin
      kick_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          gpn_pkg::RegGlobalSizeX: begin
            gsize_q[gpn_pkg::AxisX] <= cfg_data_i & GsMask;
            kick_q                  <= 1'b1;
          end
          gpn_pkg::RegGlobalSizeY: begin
            gsize_q[gpn_pkg::AxisY] <= cfg_data_i & GsMask;
            kick_q                  <= 1'b1;
          end
          gpn_pkg::RegGlobalSizeZ: begin
            gsize_q[gpn_pkg::AxisZ] <= cfg_data_i & GsMask;
            kick_q                  <= 1'b1;
          end
          gpn_pkg::RegPartsX: begin
            parts_q[gpn_pkg::AxisX] <= cfg_data_i[PW-1:0];
            kick_q                  <= 1'b1;
          end
          gpn_pkg::RegPartsY: begin
            parts_q[gpn_pkg::AxisY] <= cfg_data_i[PW-1:0];
            kick_q                  <= 1'b1;
          end
          gpn_pkg::RegPartsZ: begin
            parts_q[gpn_pkg::AxisZ] <= cfg_data_i[PW-1:0];
            kick_q                  <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // effective partition counts
  always_comb begin
    for (int a = 0; a < NA; a++) begin
      eff[a] = gpn_pkg::clamp_parts(parts_q[a], PartsLim);
    end
  end

  // axes are divided one after another through a single divider
  assign nxt_axis  = (kick_q || axis_q == 2'(LastAxis)) ? '0 : axis_q + 2'd1;
  assign div_start = kick_q || (busy_q && div_done && axis_q != 2'(LastAxis));

  gpn_div #(
    .DW (SW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (gsize_q[nxt_axis]),
    .divisor_i  (eff[nxt_axis]),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      ()
  );

  // derivation sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      axis_q <= '0;
      for (int a = 0; a < NA; a++) begin
        lsize_q[a] <= SW'(1);
      end
    end else if (kick_q) begin
      busy_q <= 1'b1;
      axis_q <= '0;
    end else if (busy_q && div_done) begin
      lsize_q[axis_q] <= div_quot;
      if (axis_q == 2'(LastAxis)) begin
        busy_q <= 1'b0;
      end else begin
        axis_q <= axis_q + 2'd1;
      end
    end
  end

  // outgoing view
  always_comb begin
    for (int a = 0; a < NA; a++) begin
      cfg_o.parts[a] = eff[a];
      cfg_o.lsize[a] = lsize_q[a];
    end
    cfg_o.busy = busy_q || kick_q;
  end

endmodule

`default_nettype wire

### rtl/gpn_front.sv
// Front end: accepts a rank and decodes it into a partition coordinate.
`default_nettype none

module gpn_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic [gpn_pkg::RankW-1:0] rank_in_i,
  input  gpn_pkg::cfg_t             cfg_i,
  input  logic                      mid_full_i,
  output logic                      mid_push_o,
  output gpn_pkg::mid_t             mid_data_o
);

  localparam int PW = gpn_pkg::PartW;
  localparam int RW = gpn_pkg::RankW;

  localparam logic [1:0] FrIdle = 2'd0;
  localparam logic [1:0] FrDivX = 2'd1;
  localparam logic [1:0] FrDivY = 2'd2;
  localparam logic [1:0] FrPush = 2'd3;

  logic [1:0]    state_q, state_d;
  gpn_pkg::mid_t ent_q, ent_d;
  logic          div_start, div_done;
  logic [RW-1:0] div_dvd, div_quot;
  logic [PW-1:0] div_dvs, div_rem;

  // rank mod px gives x; (rank / px) mod py gives y, (rank / px) / py gives z; z >= pz flags a bad rank
  always_comb begin
    state_d    = state_q;
    ent_d      = ent_q;
    div_start  = 1'b0;
    div_dvd    = rank_in_i;
    div_dvs    = cfg_i.parts[gpn_pkg::AxisX];
    mid_push_o = 1'b0;
    case (state_q)
      FrIdle: begin
        if (push_i) begin
          div_start = 1'b1;
          state_d   = FrDivX;
        end
      end
      FrDivX: begin
        if (div_done) begin
          ent_d.coord[gpn_pkg::AxisX] = div_rem;
          div_start = 1'b1;
          div_dvd   = div_quot;
          div_dvs   = cfg_i.parts[gpn_pkg::AxisY];
          state_d   = FrDivY;
        end
      end
      FrDivY: begin
        if (div_done) begin
          ent_d.coord[gpn_pkg::AxisY] = div_rem;
          ent_d.coord[gpn_pkg::AxisZ] = div_quot[PW-1:0];
          ent_d.err = (div_quot >= RW'(cfg_i.parts[gpn_pkg::AxisZ]));
          state_d   = FrPush;
        end
      end
      FrPush: begin
        if (!mid_full_i) begin
          mid_push_o = 1'b1;
          state_d    = FrIdle;
        end
      end
      default: state_d = FrIdle;
    endcase
  end

  gpn_div #(
    .DW (RW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign full_o     = (state_q != FrIdle);
  assign mid_data_o = ent_q;

endmodule

`default_nettype wire

### rtl/gpn_back.sv
// Back end: walks the 26 neighbor offsets and builds result items.
`default_nettype none

module gpn_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  gpn_pkg::cfg_t cfg_i,
  input  logic          mid_empty_i,
  input  gpn_pkg::mid_t mid_data_i,
  output logic          mid_pop_o,
  output logic          empty_o,
  input  logic          pop_i,
  output gpn_pkg::res_t res_o
);

  localparam int PW = gpn_pkg::PartW;
  localparam int NA = gpn_pkg::NumAxes;
  localparam int TW = gpn_pkg::TermW;
  localparam int SW = gpn_pkg::SizeW;
  localparam int EW = gpn_pkg::EndW;
  localparam int RW = gpn_pkg::RankW;
  localparam int PrW = PW + SW + 1;   // coord * size with headroom for the end
  localparam int RfW = PW + TW + 1;   // full rank before truncation

  localparam logic [1:0] ScIdle  = 2'd0;
  localparam logic [1:0] ScOwn   = 2'd1;
  localparam logic [1:0] ScScan  = 2'd2;
  localparam logic [1:0] ScFlush = 2'd3;

  typedef struct packed {
    logic                     valid;
    logic                     flush;
    logic                     err;
    logic [NA-1:0][PW-1:0]    c;
    logic [TW-1:0]            t;
  } tok_t;

  logic [1:0]    st_q;
  logic [PW-1:0] own_q [NA];
  logic [1:0]    off_q [NA];
  logic          err_q;
  tok_t          tok, s1_q;
  gpn_pkg::res_t pend_q, calc, push_data;
  logic          pend_valid_q;
  logic          adv, ofifo_full, ofifo_push;
  logic [PW:0]   sum   [NA];
  logic          inb   [NA];
  logic          center;
  logic [RfW-1:0] rank_full;
  logic [PrW-1:0] prod [NA];
  logic [PrW-1:0] endv [NA];

  // the whole back pipeline moves when the output queue has room
  assign adv       = !ofifo_full;
  assign mid_pop_o = (st_q == ScIdle) && !mid_empty_i && !cfg_i.busy;

  // neighbor candidate: own + offset - 1, in bounds when 0 <= v < parts
  always_comb begin
    for (int a = 0; a < NA; a++) begin
      sum[a] = {1'b0, own_q[a]} + (PW + 1)'(off_q[a]);
      inb[a] = (sum[a] != '0) && (sum[a] <= {1'b0, cfg_i.parts[a]});
    end
    center = (off_q[0] == 2'd1) && (off_q[1] == 2'd1) && (off_q[2] == 2'd1);
  end

  // token for the current scan step
  always_comb begin
    tok = '0;
    case (st_q)
      ScOwn: begin
        tok.valid = 1'b1;
        tok.err   = err_q;
        for (int a = 0; a < NA; a++) begin
          tok.c[a] = own_q[a];
        end
      end
      ScScan: begin
        tok.valid = inb[0] && inb[1] && inb[2] && !center;
        for (int a = 0; a < NA; a++) begin
          tok.c[a] = PW'(sum[a] - (PW + 1)'(1));
        end
      end
      ScFlush: tok.flush = 1'b1;
      default: ;
    endcase
    tok.t = TW'(tok.c[gpn_pkg::AxisY])
          + TW'(cfg_i.parts[gpn_pkg::AxisY]) * TW'(tok.c[gpn_pkg::AxisZ]);
  end

  // scan sequencer: own partition, then offsets x outer, z inner, then flush; a bad rank skips the scan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ScIdle;
      err_q <= 1'b0;
      for (int a = 0; a < NA; a++) begin
        own_q[a] <= '0;
        off_q[a] <= '0;
      end
    end else begin
      case (st_q)
        ScIdle: begin
          if (mid_pop_o) begin
            st_q  <= ScOwn;
            err_q <= mid_data_i.err;
            for (int a = 0; a < NA; a++) begin
              off_q[a] <= '0;
            end
            if (!mid_data_i.err) begin
              for (int a = 0; a < NA; a++) begin
                own_q[a] <= mid_data_i.coord[a];
              end
            end
          end
        end
        ScOwn: begin
          if (adv) begin
            st_q <= err_q ? ScFlush : ScScan;
          end
        end
        ScScan: begin
          if (adv) begin
            if (off_q[2] != 2'd2) begin
              off_q[2] <= off_q[2] + 2'd1;
            end else begin
              off_q[2] <= '0;
              if (off_q[1] != 2'd2) begin
                off_q[1] <= off_q[1] + 2'd1;
              end else begin
                off_q[1] <= '0;
                if (off_q[0] != 2'd2) begin
                  off_q[0] <= off_q[0] + 2'd1;
                end else begin
                  st_q <= ScFlush;
                end
              end
            end
          end
        end
        ScFlush: begin
          if (adv) begin
            st_q <= ScIdle;
          end
        end
        default: st_q <= ScIdle;
      endcase
    end
  end

  // stage 1 register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (adv) begin
      s1_q <= tok;
    end
  end

  // stage 2: rank and bounding box
  always_comb begin
    calc      = '0;
    rank_full = RfW'(s1_q.c[gpn_pkg::AxisX])
              + RfW'(cfg_i.parts[gpn_pkg::AxisX]) * RfW'(s1_q.t);
    for (int a = 0; a < NA; a++) begin
      prod[a] = PrW'(s1_q.c[a]) * PrW'(cfg_i.lsize[a]);
      endv[a] = prod[a] + PrW'(cfg_i.lsize[a]) - PrW'(1);
    end
    if (s1_q.err) begin
      calc.rank_error = 1'b1;
    end else begin
      calc.rank = rank_full[RW-1:0];
      for (int a = 0; a < NA; a++) begin
        calc.part[a]     = s1_q.c[a][gpn_pkg::CoordW-1:0];
        calc.first[a]    = prod[a][SW-1:0];
        calc.lastcell[a] = endv[a][EW-1:0];
      end
    end
  end

  // hold one result back so the final one of a run can be marked
  assign ofifo_push = adv && ((s1_q.valid && pend_valid_q) || s1_q.flush);
  always_comb begin
    push_data      = pend_q;
    push_data.last = s1_q.flush;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (adv) begin
      if (s1_q.valid) begin
        pend_valid_q <= 1'b1;
      end else if (s1_q.flush) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_q.valid) begin
      pend_q <= calc;
    end
  end

  // result queue
  gpn_fifo #(
    .W     ($bits(gpn_pkg::res_t)),
    .DEPTH (2)
  ) u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ofifo_push),
    .data_i  (push_data),
    .full_o  (ofifo_full),
    .pop_i   (pop_i),
    .data_o  (res_o),
    .empty_o (empty_o)
  );

  // a run always has at least one held result when it closes
  a_flush_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_q.flush) |-> pend_valid_q)
    else $error("flush with no held result");

  // neighbor coordinates stay inside the partition grid
  a_token_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_q.valid && !s1_q.err) |->
      (s1_q.c[0] < cfg_i.parts[0] && s1_q.c[1] < cfg_i.parts[1] &&
       s1_q.c[2] < cfg_i.parts[2]))
    else $error("candidate outside the grid");

  // a bad rank is followed directly by the end of its run
  a_err_then_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_q.valid && s1_q.err) |=> s1_q.flush)
    else $error("error result not closed at once");

  // an error result is always the last of its run
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ofifo_push && push_data.rank_error) |-> push_data.last)
    else $error("error result not marked last");

endmodule

`default_nettype wire

### rtl/grid_partition_neighbor_generator_core.sv
// Decode: the front divides each rank twice through one divider (two 12-step divisions);
//   the first result of a rank is held back until the next result or the end of its run.
// Scan: the back end's 27-step offset scan issues at most one result per cycle while the
//   output queue has room; the front decodes the next rank meanwhile.
// Reset: all queues empty, registers at 1, local sizes at 1; after a register write the
//   local sizes are derived anew, axis by axis, before the back end starts a run.
`default_nettype none

module grid_partition_neighbor_generator_core #(
  parameter int MAX_PARTS_PER_AXIS = 16,
  parameter int COORD_WIDTH        = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [gpn_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gpn_pkg::CfgDataW-1:0] cfg_data_i,
  // input queue side
  input  logic                         push,
  output logic                         full,
  input  logic [11:0]                  rank_in_i,
  // result queue side
  output logic                         empty,
  input  logic                         pop,
  output logic                         rank_error_o,
  output logic [3:0]                   part_x_o,
  output logic [3:0]                   part_y_o,
  output logic [3:0]                   part_z_o,
  output logic [11:0]                  part_rank_o,
  output logic [15:0]                  start_x_o,
  output logic [15:0]                  start_y_o,
  output logic [15:0]                  start_z_o,
  output logic signed [16:0]           end_x_o,
  output logic signed [16:0]           end_y_o,
  output logic signed [16:0]           end_z_o,
  output logic                         last_o
);

  gpn_pkg::cfg_t cfg;
  gpn_pkg::mid_t mid_in, mid_out;
  gpn_pkg::res_t res;
  logic          mid_push, mid_full, mid_pop, mid_empty;

  assign cfg_ready_o = 1'b1;

  gpn_cfg #(
    .MAX_PARTS_PER_AXIS (MAX_PARTS_PER_AXIS),
    .COORD_WIDTH        (COORD_WIDTH)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  gpn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .rank_in_i  (rank_in_i),
    .cfg_i      (cfg),
    .mid_full_i (mid_full),
    .mid_push_o (mid_push),
    .mid_data_o (mid_in)
  );

  // decoupling queue between decode and scan
  gpn_fifo #(
    .W     ($bits(gpn_pkg::mid_t)),
    .DEPTH (2)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty)
  );

  gpn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .mid_empty_i (mid_empty),
    .mid_data_i  (mid_out),
    .mid_pop_o   (mid_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  // result fields
  assign rank_error_o = res.rank_error;
  assign part_x_o     = res.part[gpn_pkg::AxisX];
  assign part_y_o     = res.part[gpn_pkg::AxisY];
  assign part_z_o     = res.part[gpn_pkg::AxisZ];
  assign part_rank_o  = res.rank;
  assign start_x_o    = res.first[gpn_pkg::AxisX];
  assign start_y_o    = res.first[gpn_pkg::AxisY];
  assign start_z_o    = res.first[gpn_pkg::AxisZ];
  assign end_x_o      = res.lastcell[gpn_pkg::AxisX];
  assign end_y_o      = res.lastcell[gpn_pkg::AxisY];
  assign end_z_o      = res.lastcell[gpn_pkg::AxisZ];
  assign last_o       = res.last;

endmodule

`default_nettype wire

### tb/gpn_neighbor_checker.sv
// Checker for the grid partition neighbor generator: predicts every neighbor list and compares.
`timescale 1ns / 100ps

module gpn_neighbor_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [gpn_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gpn_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         push,
  input  logic                         full,
  input  logic [11:0]                  rank_in_i,
  input  logic                         empty,
  input  logic                         pop,
  input  logic                         rank_error_i,
  input  logic [3:0]                   part_x_i,
  input  logic [3:0]                   part_y_i,
  input  logic [3:0]                   part_z_i,
  input  logic [11:0]                  part_rank_i,
  input  logic [15:0]                  start_x_i,
  input  logic [15:0]                  start_y_i,
  input  logic [15:0]                  start_z_i,
  input  logic [16:0]                  end_x_i,
  input  logic [16:0]                  end_y_i,
  input  logic [16:0]                  end_z_i,
  input  logic                         last_i,
  output int                           mismatch_cnt_o,
  output int                           pending_o
);

  localparam int MaxParts = 16;

  // one partition block as reported; axis 0 is x
  typedef struct packed {
    logic             rank_error;
    logic [2:0][3:0]  part;
    logic [11:0]      rank;
    logic [2:0][15:0] first;
    logic [2:0][16:0] bound;
    logic             last;
  } nbr_block_t;

  string axis_tag [3] = '{"x", "y", "z"};

  nbr_block_t  nbr_expected_q [$];
  logic [15:0] grid_cells [3];
  logic [4:0]  parts_raw [3];
  int          mismatches;

  // count in use: zero acts as one, anything above the limit as the limit
  function automatic int eff_parts(input int axis);
    int p;
    p = parts_raw[axis];
    if (p < 1) p = 1;
    if (p > MaxParts) p = MaxParts;
    return p;
  endfunction

  // coordinate, rank and inclusive box of one partition
  function automatic nbr_block_t block_box(input int x, input int y, input int z);
    nbr_block_t b;
    int         c [3];
    int         lsz;
    int         s;
    c = '{x, y, z};
    b = '0;
    b.rank = 12'(x + eff_parts(gpn_pkg::AxisX) * (y + eff_parts(gpn_pkg::AxisY) * z));
    for (int a = 0; a < 3; a++) begin
      lsz        = grid_cells[a] / eff_parts(a);
      s          = c[a] * lsz;
      b.part[a]  = 4'(c[a]);
      b.first[a] = 16'(s);
      b.bound[a] = 17'(s + lsz - 1);  // all ones when the block is empty
    end
    return b;
  endfunction

  // own block first, then in-bounds neighbors with x outer and z inner; a bad rank gives one error entry
  task automatic predict_neighbors(input logic [11:0] rank);
    nbr_block_t batch [$];
    nbr_block_t e;
    int         px;
    int         py;
    int         pz;
    int         o [3];
    px = eff_parts(gpn_pkg::AxisX);
    py = eff_parts(gpn_pkg::AxisY);
    pz = eff_parts(gpn_pkg::AxisZ);
    if (int'(rank) >= px * py * pz) begin
      e            = '0;
      e.rank_error = 1'b1;
      e.last       = 1'b1;
      nbr_expected_q = {nbr_expected_q, e};
      return;
    end
    o[0] = rank % px;
    o[1] = (rank / px) % py;
    o[2] = rank / (px * py);
    batch = {batch, block_box(o[0], o[1], o[2])};
    for (int dx = -1; dx <= 1; dx++) begin
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dz = -1; dz <= 1; dz++) begin
          if (dx == 0 && dy == 0 && dz == 0) continue;
          if (o[0] + dx < 0 || o[0] + dx >= px) continue;
          if (o[1] + dy < 0 || o[1] + dy >= py) continue;
          if (o[2] + dz < 0 || o[2] + dz >= pz) continue;
          batch = {batch, block_box(o[0] + dx, o[1] + dy, o[2] + dz)};
        end
      end
    end
    batch[batch.size() - 1].last = 1'b1;
    nbr_expected_q = {nbr_expected_q, batch};
  endtask

  task automatic check_field(input string name, input logic [16:0] want,
                             input logic [16:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // compare one popped result with the oldest expectation
  task automatic check_result();
    nbr_block_t got;
    nbr_block_t want;
    got.rank_error = rank_error_i;
    got.part       = {part_z_i, part_y_i, part_x_i};
    got.rank       = part_rank_i;
    got.first      = {start_z_i, start_y_i, start_x_i};
    got.bound      = {end_z_i, end_y_i, end_x_i};
    got.last       = last_i;
    if (nbr_expected_q.size() == 0) begin
      $error("result transfer with nothing expected (part_rank 0x%0h)", part_rank_i);
      mismatches++;
      return;
    end
    want = nbr_expected_q.pop_front();
    check_field("rank_error", 17'(want.rank_error), 17'(got.rank_error));
    check_field("part_rank", 17'(want.rank), 17'(got.rank));
    check_field("last", 17'(want.last), 17'(got.last));
    for (int a = 0; a < 3; a++) begin
      check_field({"part_", axis_tag[a]}, 17'(want.part[a]), 17'(got.part[a]));
      check_field({"start_", axis_tag[a]}, 17'(want.first[a]), 17'(got.first[a]));
      check_field({"end_", axis_tag[a]}, want.bound[a], got.bound[a]);
    end
  endtask

  // watch all three channels; results first, then register writes, then ranks
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nbr_expected_q.delete();
      foreach (grid_cells[a]) begin
        grid_cells[a] = 16'd1;
        parts_raw[a]  = 5'd1;
      end
      mismatches     = 0;
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
    end else begin
      if (pop && !empty) check_result();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          gpn_pkg::RegGlobalSizeX: grid_cells[gpn_pkg::AxisX] = cfg_data_i;
          gpn_pkg::RegGlobalSizeY: grid_cells[gpn_pkg::AxisY] = cfg_data_i;
          gpn_pkg::RegGlobalSizeZ: grid_cells[gpn_pkg::AxisZ] = cfg_data_i;
          gpn_pkg::RegPartsX:      parts_raw[gpn_pkg::AxisX]  = cfg_data_i[4:0];
          gpn_pkg::RegPartsY:      parts_raw[gpn_pkg::AxisY]  = cfg_data_i[4:0];
          gpn_pkg::RegPartsZ:      parts_raw[gpn_pkg::AxisZ]  = cfg_data_i[4:0];
          default: ;  // unmapped index, write dropped
        endcase
      end
      if (push && !full) predict_neighbors(rank_in_i);
      mismatch_cnt_o <= mismatches;
      pending_o      <= nbr_expected_q.size();
    end
  end

endmodule

### tb/tb_grid_partition_neighbor_generator_core.sv
// Testbench top: stimulus, idle patterns and verdict for the neighbor generator core.
`timescale 1ns / 100ps

module tb_grid_partition_neighbor_generator_core;

  // the watchdog limit allows for local size settling after a config write, the wait for
  // the first result, and runs of random stalls at 60 percent
  localparam int WatchdogLimit = 4000;
  localparam int SettleCycles  = 64;
  localparam int RanksPerPhase = 20;

  // unmapped register indexes
  localparam logic [gpn_pkg::CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [gpn_pkg::CfgIdxW-1:0] RegSpareHi = 3'd7;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [gpn_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [gpn_pkg::CfgDataW-1:0] cfg_data_i  = '0;
  logic                         push        = 1'b0;
  logic                         full;
  logic [11:0]                  rank_in_i   = '0;
  logic                         empty;
  logic                         pop         = 1'b0;
  logic                         rank_error_o;
  logic [3:0]                   part_x_o;
  logic [3:0]                   part_y_o;
  logic [3:0]                   part_z_o;
  logic [11:0]                  part_rank_o;
  logic [15:0]                  start_x_o;
  logic [15:0]                  start_y_o;
  logic [15:0]                  start_z_o;
  logic signed [16:0]           end_x_o;
  logic signed [16:0]           end_y_o;
  logic signed [16:0]           end_z_o;
  logic                         last_o;

  int mismatch_cnt;
  int pending_blocks;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int rank_span     = 1;
  int idle_cycles   = 0;

  int phase_idle  [4] = '{0, 60, 0, 17};
  int phase_stall [4] = '{0, 0, 60, 17};

  always #2 clk_i = ~clk_i;

  grid_partition_neighbor_generator_core u_dut (.*);

  gpn_neighbor_checker u_checker (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .push,
    .full,
    .rank_in_i,
    .empty,
    .pop,
    .rank_error_i   (rank_error_o),
    .part_x_i       (part_x_o),
    .part_y_i       (part_y_o),
    .part_z_i       (part_z_o),
    .part_rank_i    (part_rank_o),
    .start_x_i      (start_x_o),
    .start_y_i      (start_y_o),
    .start_z_i      (start_z_o),
    .end_x_i        (end_x_o),
    .end_y_i        (end_y_o),
    .end_z_i        (end_z_o),
    .last_i         (last_o),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_blocks)
  );

  // result side: random back-pressure at the current stall rate
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WatchdogLimit) begin
        $display("tb_grid_partition_neighbor_generator_core: FAIL");
        $finish;
      end
    end
  end

  // one rank transfer; push stays high for a following rank unless a gap is drawn
  task automatic send_rank(input logic [11:0] r);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    rank_in_i <= r;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [gpn_pkg::CfgIdxW-1:0] idx,
                           input logic [gpn_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // program all six registers and track how many ranks are valid
  task automatic set_grid(input logic [15:0] gx, input logic [15:0] gy,
                          input logic [15:0] gz, input logic [15:0] px,
                          input logic [15:0] py, input logic [15:0] pz);
    int cnt [3];
    write_reg(gpn_pkg::RegGlobalSizeX, gx);
    write_reg(gpn_pkg::RegGlobalSizeY, gy);
    write_reg(gpn_pkg::RegGlobalSizeZ, gz);
    write_reg(gpn_pkg::RegPartsX, px);
    write_reg(gpn_pkg::RegPartsY, py);
    write_reg(gpn_pkg::RegPartsZ, pz);
    cfg_valid_i <= 1'b0;
    cnt = '{int'(px[4:0]), int'(py[4:0]), int'(pz[4:0])};
    foreach (cnt[a]) cnt[a] = (cnt[a] == 0) ? 1 : ((cnt[a] > 16) ? 16 : cnt[a]);
    rank_span = cnt[0] * cnt[1] * cnt[2];
  endtask

  // stop sending and wait until every expected block has been popped
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_blocks != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [11:0] pick_rank();
    if ($urandom_range(99) < 85) return 12'($urandom_range(rank_span - 1));
    return 12'($urandom_range(4095));
  endfunction

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset grid: a single one-cell partition, everything else out of range
    send_rank(12'd0);
    send_rank(12'd1);
    send_rank(12'd4095);
    drain();

    // unmapped writes, empty x blocks, zero and oversized counts, stray data bits
    write_reg(RegSpareLo, 16'hFFFF);
    write_reg(RegSpareHi, 16'hFFFF);
    set_grid(16'd0, 16'd7, 16'hFFFF, 16'hFFE3, 16'hFFE0, 16'd31);
    send_rank(12'd0);
    send_rank(12'd47);
    send_rank(12'd48);
    send_rank(12'd25);
    drain();

    // largest grid: corners and an interior block
    set_grid(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd16, 16'd16, 16'd16);
    send_rank(12'd0);
    send_rank(12'd4095);
    send_rank(12'd1365);
    send_rank(12'd15);
    send_rank(12'd3840);
    drain();

    // 2x2x2 with empty y blocks: every rank plus the first bad one
    set_grid(16'hFFFF, 16'd1, 16'd4, 16'd2, 16'd2, 16'd2);
    for (int r = 0; r <= 8; r++) send_rank(12'(r));
    drain();

    // random grids, one idle pattern each
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = phase_idle[phase];
      pop_stall_pct = phase_stall[phase];
      case (phase)
        0: set_grid(16'($urandom()), 16'($urandom()), 16'($urandom()),
                    16'd16, 16'd16, 16'd16);
        1: set_grid(16'($urandom()), 16'($urandom()), 16'($urandom()),
                    16'($urandom_range(1, 16)), 16'($urandom_range(1, 16)),
                    16'($urandom_range(1, 16)));
        2: set_grid(16'($urandom_range(0, 64)), 16'($urandom_range(0, 64)),
                    16'($urandom_range(0, 64)), 16'($urandom()), 16'($urandom()),
                    16'($urandom()));
        default: set_grid(16'($urandom()), 16'($urandom()), 16'($urandom()),
                          16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                          16'($urandom_range(1, 4)));
      endcase
      repeat (RanksPerPhase) send_rank(pick_rank());
      drain();
    end

    if (mismatch_cnt == 0 && pending_blocks == 0) begin
      $display("tb_grid_partition_neighbor_generator_core: PASS");
    end else begin
      $display("tb_grid_partition_neighbor_generator_core: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/gpn_pkg.sv
rtl/gpn_div.sv
rtl/gpn_fifo.sv
rtl/gpn_cfg.sv
rtl/gpn_front.sv
rtl/gpn_back.sv
rtl/grid_partition_neighbor_generator_core.sv
tb/gpn_neighbor_checker.sv
tb/tb_grid_partition_neighbor_generator_core.sv
